@@ rtl/lpg_pkg.sv @@
// Package for the line pixel generator: shared types and default constants.
// No dependencies; every other file of the block imports it.
package lpg_pkg;

  // Default coordinate width in bits.
  localparam int COORD_WIDTH_DEFAULT = 10;

  // Command codes carried by the operation field.
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // Step direction of one axis.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_t;

endpackage

@@ rtl/lpg_cmd_if.sv @@
// Command channel of the line pixel generator: valid/ready plus line endpoints.
// Depends on lpg_pkg for the command code type.
interface lpg_cmd_if #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
);
  import lpg_pkg::*;

  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [COORD_WIDTH-1:0] x_start;
  logic [COORD_WIDTH-1:0] y_start;
  logic [COORD_WIDTH-1:0] x_end;
  logic [COORD_WIDTH-1:0] y_end;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end,
    input  ready
  );

  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end,
    output ready
  );

endinterface

@@ rtl/lpg_pix_if.sv @@
// Pixel channel of the line pixel generator: valid/ready plus one pixel.
// Depends on lpg_pkg for the default width.
interface lpg_pix_if #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
);
  import lpg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] pixel_x;
  logic [COORD_WIDTH-1:0] pixel_y;
  logic                   last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );

endinterface

@@ rtl/lpg_setup.sv @@
// Line setup: absolute deltas, step directions and major distance of a line.
// Depends on lpg_pkg for the direction type.
module lpg_setup #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic [COORD_WIDTH-1:0] x_start,
  input  logic [COORD_WIDTH-1:0] y_start,
  input  logic [COORD_WIDTH-1:0] x_end,
  input  logic [COORD_WIDTH-1:0] y_end,
  output logic [COORD_WIDTH-1:0] abs_dx,
  output logic [COORD_WIDTH-1:0] abs_dy,
  output logic [COORD_WIDTH-1:0] major_dist,
  output lpg_pkg::dir_t          dir_col,
  output lpg_pkg::dir_t          dir_row
);
  import lpg_pkg::*;

  // Column delta and direction.
  always_comb begin
    if (x_end > x_start) begin
      abs_dx  = x_end - x_start;
      dir_col = DIR_POS;
    end else if (x_end == x_start) begin
      abs_dx  = '0;
      dir_col = DIR_NONE;
    end else begin
      abs_dx  = x_start - x_end;
      dir_col = DIR_NEG;
    end
  end

  // Row delta and direction.
  always_comb begin
    if (y_end > y_start) begin
      abs_dy  = y_end - y_start;
      dir_row = DIR_POS;
    end else if (y_end == y_start) begin
      abs_dy  = '0;
      dir_row = DIR_NONE;
    end else begin
      abs_dy  = y_start - y_end;
      dir_row = DIR_NEG;
    end
  end

  // The larger delta sets the number of steps.
  assign major_dist = (abs_dx > abs_dy) ? abs_dx : abs_dy;

endmodule

@@ rtl/lpg_axis.sv @@
// One axis of the stepping rule: error accumulation and coordinate move.
// Depends on lpg_pkg for the direction type.
module lpg_axis #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic [COORD_WIDTH:0]   err,
  input  logic [COORD_WIDTH-1:0] delta,
  input  logic [COORD_WIDTH-1:0] major_dist,
  input  logic [COORD_WIDTH-1:0] coord,
  input  lpg_pkg::dir_t          dir,
  output logic [COORD_WIDTH:0]   err_next,
  output logic [COORD_WIDTH-1:0] coord_next
);
  import lpg_pkg::*;

  logic [COORD_WIDTH:0]   err_sum;
  logic [COORD_WIDTH:0]   major_ext;
  logic                   overflow;
  logic [COORD_WIDTH-1:0] coord_moved;

  // The error grows by the delta; once past the major distance it wraps back.
  assign major_ext = {1'b0, major_dist};
  assign err_sum   = err + {1'b0, delta};
  assign overflow  = (err_sum > major_ext);
  assign err_next  = overflow ? (err_sum - major_ext) : err_sum;

  // Coordinate moves one unit in the axis direction, wrapping at the edges.
  always_comb begin
    unique case (dir)
      DIR_POS: coord_moved = coord + COORD_WIDTH'(1);
      DIR_NEG: coord_moved = coord - COORD_WIDTH'(1);
      default: coord_moved = coord;
    endcase
  end

  assign coord_next = overflow ? coord_moved : coord;

endmodule

@@ rtl/line_pixel_generator_core.sv @@
// Top level of the line pixel generator: command register, line state and
// pixel output register. Depends on lpg_pkg, lpg_cmd_if, lpg_pix_if,
// lpg_setup and lpg_axis.
//
//   Channel | Modport | Transaction
//   --------+---------+-----------------------------------------------------
//   cmd     | sink    | start a line (two endpoints) or step to next pixel
//   pix     | source  | one pixel: column, row and last-pixel mark
//
// A command transaction is registered in the command register, processed against
// the line state when the output register can take it, and its pixel is shown from
// the output register; one command per cycle is sustained while the output does not stall.
// Synchronous reset makes the block idle and drops any pending transaction.
// A stalled pixel output holds the command register; commands keep flowing
// while the output register is free or being emptied in the same cycle.
module line_pixel_generator_core #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lpg_cmd_if.sink   cmd,
  lpg_pix_if.source pix
);
  import lpg_pkg::*;

  localparam int ErrWidth = COORD_WIDTH + 1;

  // Command register.
  logic                   cmd_valid_q;
  op_t                    cmd_op_q;
  logic [COORD_WIDTH-1:0] cmd_xs_q;
  logic [COORD_WIDTH-1:0] cmd_ys_q;
  logic [COORD_WIDTH-1:0] cmd_xe_q;
  logic [COORD_WIDTH-1:0] cmd_ye_q;

  // Line state.
  logic                   busy;
  logic [COORD_WIDTH-1:0] cur_col;
  logic [COORD_WIDTH-1:0] cur_row;
  logic [ErrWidth-1:0]    err_col;
  logic [ErrWidth-1:0]    err_row;
  logic [COORD_WIDTH-1:0] abs_dx;
  logic [COORD_WIDTH-1:0] abs_dy;
  logic [COORD_WIDTH-1:0] major_dist;
  dir_t                   dir_col;
  dir_t                   dir_row;
  logic [ErrWidth-1:0]    pixel_count;

  // Output register.
  logic                   out_valid;
  logic [COORD_WIDTH-1:0] out_x;
  logic [COORD_WIDTH-1:0] out_y;
  logic                   out_last;

  // Combinational results.
  logic                   out_free;
  logic                   cmd_fire;
  logic                   proc_start;
  logic                   proc_step;
  logic [COORD_WIDTH-1:0] setup_dx;
  logic [COORD_WIDTH-1:0] setup_dy;
  logic [COORD_WIDTH-1:0] setup_major;
  dir_t                   setup_dir_col;
  dir_t                   setup_dir_row;
  logic [ErrWidth-1:0]    err_col_next;
  logic [ErrWidth-1:0]    err_row_next;
  logic [COORD_WIDTH-1:0] cur_col_next;
  logic [COORD_WIDTH-1:0] cur_row_next;
  logic [ErrWidth-1:0]    pixel_count_next;
  logic                   step_last;

  // Handshake: the command register moves on when the output register can take it.
  assign out_free   = !out_valid || pix.ready;
  assign cmd_fire   = cmd_valid_q && out_free;
  assign cmd.ready  = !cmd_valid_q || out_free;
  assign proc_start = cmd_fire && (cmd_op_q == OP_START);
  assign proc_step  = cmd_fire && (cmd_op_q == OP_STEP) && busy;

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_fire) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_op_q <= cmd.operation;
      cmd_xs_q <= cmd.x_start;
      cmd_ys_q <= cmd.y_start;
      cmd_xe_q <= cmd.x_end;
      cmd_ye_q <= cmd.y_end;
    end
  end

  // Line setup from the registered endpoints.
  lpg_setup #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_setup (
    .x_start    (cmd_xs_q),
    .y_start    (cmd_ys_q),
    .x_end      (cmd_xe_q),
    .y_end      (cmd_ye_q),
    .abs_dx     (setup_dx),
    .abs_dy     (setup_dy),
    .major_dist (setup_major),
    .dir_col    (setup_dir_col),
    .dir_row    (setup_dir_row)
  );

  // Per-axis stepping.
  lpg_axis #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_axis_col (
    .err        (err_col),
    .delta      (abs_dx),
    .major_dist (major_dist),
    .coord      (cur_col),
    .dir        (dir_col),
    .err_next   (err_col_next),
    .coord_next (cur_col_next)
  );

  lpg_axis #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_axis_row (
    .err        (err_row),
    .delta      (abs_dy),
    .major_dist (major_dist),
    .coord      (cur_row),
    .dir        (dir_row),
    .err_next   (err_row_next),
    .coord_next (cur_row_next)
  );

  // A line has the major distance plus two pixels.
  assign pixel_count_next = pixel_count + ErrWidth'(1);
  assign step_last        = (pixel_count_next == ({1'b0, major_dist} + ErrWidth'(2)));

  // Line state. A start gives the start pixel, which is never the last, and
  // itself loads the deltas into the errors: no delta can
  // exceed the major distance, so no coordinate moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (proc_start) begin
      busy <= 1'b1;
    end else if (proc_step && step_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_start) begin
      abs_dx      <= setup_dx;
      abs_dy      <= setup_dy;
      major_dist  <= setup_major;
      dir_col     <= setup_dir_col;
      dir_row     <= setup_dir_row;
      cur_col     <= cmd_xs_q;
      cur_row     <= cmd_ys_q;
      err_col     <= {1'b0, setup_dx};
      err_row     <= {1'b0, setup_dy};
      pixel_count <= ErrWidth'(1);
    end else if (proc_step) begin
      pixel_count <= pixel_count_next;
      if (!step_last) begin
        err_col <= err_col_next;
        err_row <= err_row_next;
        cur_col <= cur_col_next;
        cur_row <= cur_row_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_start || proc_step) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_start) begin
      out_x    <= cmd_xs_q;
      out_y    <= cmd_ys_q;
      out_last <= 1'b0;
    end else if (proc_step) begin
      out_x    <= cur_col;
      out_y    <= cur_row;
      out_last <= step_last;
    end
  end

  assign pix.valid      = out_valid;
  assign pix.pixel_x    = out_x;
  assign pix.pixel_y    = out_y;
  assign pix.last_pixel = out_last;

endmodule

@@ rtl/lpg_checker.sv @@
// Port-level checks for line_pixel_generator_core and the bind that attaches them.
// Depends on lpg_pkg and on the top level's ports.
module lpg_checker #(
  parameter int COORD_WIDTH = lpg_pkg::COORD_WIDTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_ready,
  input logic                   pix_valid,
  input logic                   pix_ready,
  input logic [COORD_WIDTH-1:0] pix_x,
  input logic [COORD_WIDTH-1:0] pix_y,
  input logic                   pix_last
);
  import lpg_pkg::*;

  logic pix_fire;

  assign pix_fire = pix_valid && pix_ready;

  // A stalled pixel keeps its valid and payload.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=>
      pix_valid && $stable(pix_x) && $stable(pix_y) && $stable(pix_last))
    else $error("pixel changed while stalled");

  // Reset leaves no pixel pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid after reset");

  // A pixel taken from the output always frees room for a new command.
  a_cmd_flow: assert property (@(posedge clk) disable iff (rst)
    pix_ready |-> cmd_ready)
    else $error("command stalled while output drains");

  // The pixel after a last pixel opens a new line, so it is never last.
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (pix_fire && pix_last) ##1 pix_fire |-> !pix_last)
    else $error("two last pixels in a row");

endmodule

bind line_pixel_generator_core lpg_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_lpg_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_x     (pix.pixel_x),
  .pix_y     (pix.pixel_y),
  .pix_last  (pix.last_pixel)
);

@@ bench/tb_line_pixel_generator_core.sv @@
// Self-checking testbench for line_pixel_generator_core: directed and random lines
// with a pixel predictor built in. Depends on lpg_pkg, lpg_cmd_if, lpg_pix_if and the RTL.
module tb_line_pixel_generator_core;
  import lpg_pkg::*;

  localparam int CW = COORD_WIDTH_DEFAULT;
  localparam int COORD_MAX = (1 << CW) - 1;
  localparam int SETTLE_CYCLES = 16;

  typedef logic [CW-1:0] coord_t;
  typedef logic [CW:0] acc_t;

  typedef struct packed {
    op_t    op;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
  } line_cmd_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;

  lpg_cmd_if #(.COORD_WIDTH(CW)) cmd_bus ();
  lpg_pix_if #(.COORD_WIDTH(CW)) pix_bus ();

  line_pixel_generator_core #(.COORD_WIDTH(CW)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .pix(pix_bus)
  );

  always #2 clk = ~clk;

  // Pixels still owed by the block, oldest first.
  pixel_t pending_pixels[$];
  int     pixels_predicted = 0;
  int     failures = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  // Predictor copy of the line engine state.
  bit     line_busy = 1'b0;
  coord_t pos_x = '0;
  coord_t pos_y = '0;
  acc_t   acc_x = '0;
  acc_t   acc_y = '0;
  coord_t span_x = '0;
  coord_t span_y = '0;
  coord_t span_major = '0;
  dir_t   dir_x = DIR_NONE;
  dir_t   dir_y = DIR_NONE;
  acc_t   drawn = '0;

  function automatic void axis_span(input coord_t a, input coord_t b, output coord_t mag,
                                    output dir_t dir);
    if (b > a) begin
      mag = b - a;
      dir = DIR_POS;
    end else if (b == a) begin
      mag = '0;
      dir = DIR_NONE;
    end else begin
      mag = a - b;
      dir = DIR_NEG;
    end
  endfunction

  function automatic coord_t step_coord(input coord_t c, input dir_t d);
    case (d)
      DIR_POS: return c + 1'b1;
      DIR_NEG: return c - 1'b1;
      default: return c;
    endcase
  endfunction

  // Works out the pixel caused by one command; returns 0 when none is due.
  function automatic bit predict_pixel(input line_cmd_t c, output pixel_t p);
    p = '0;
    if (c.op == OP_START) begin
      axis_span(c.xs, c.xe, span_x, dir_x);
      axis_span(c.ys, c.ye, span_y, dir_y);
      span_major = (span_x > span_y) ? span_x : span_y;
      pos_x = c.xs;
      pos_y = c.ys;
      acc_x = '0;
      acc_y = '0;
      drawn = '0;
      line_busy = 1'b1;
    end else if (!line_busy) begin
      return 1'b0;
    end
    p.col = pos_x;
    p.row = pos_y;
    drawn = drawn + 1'b1;
    p.last = (drawn == acc_t'(span_major) + acc_t'(2));
    if (p.last) begin
      line_busy = 1'b0;
      return 1'b1;
    end
    // Each axis error gains its delta and moves the coordinate on overflow.
    acc_x = acc_x + acc_t'(span_x);
    if (acc_x > acc_t'(span_major)) begin
      acc_x = acc_x - acc_t'(span_major);
      pos_x = step_coord(pos_x, dir_x);
    end
    acc_y = acc_y + acc_t'(span_y);
    if (acc_y > acc_t'(span_major)) begin
      acc_y = acc_y - acc_t'(span_major);
      pos_y = step_coord(pos_y, dir_y);
    end
    return 1'b1;
  endfunction

  function automatic line_cmd_t rand_cmd(input op_t op);
    line_cmd_t c;
    c.op = op;
    c.xs = coord_t'($urandom_range(COORD_MAX));
    c.ys = coord_t'($urandom_range(COORD_MAX));
    c.xe = coord_t'($urandom_range(COORD_MAX));
    c.ye = coord_t'($urandom_range(COORD_MAX));
    return c;
  endfunction

  // Endpoint near the start point, mostly short, clamped to the panel.
  function automatic coord_t pick_end(input coord_t s);
    int d;
    int e;
    d = ($urandom_range(99) < 88) ? $urandom_range(12) : $urandom_range(COORD_MAX);
    e = $urandom_range(1) ? int'(s) + d : int'(s) - d;
    if (e < 0) e = 0;
    if (e > COORD_MAX) e = COORD_MAX;
    return coord_t'(e);
  endfunction

  // Sends one command transaction, with random idle cycles ahead of it.
  task automatic send_cmd(input line_cmd_t c);
    pixel_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid     <= 1'b0;
      cmd_bus.operation <= op_t'($urandom_range(1));
      cmd_bus.x_start   <= coord_t'($urandom);
      cmd_bus.y_start   <= coord_t'($urandom);
      cmd_bus.x_end     <= coord_t'($urandom);
      cmd_bus.y_end     <= coord_t'($urandom);
      @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= c.op;
    cmd_bus.x_start   <= c.xs;
    cmd_bus.y_start   <= c.ys;
    cmd_bus.x_end     <= c.xe;
    cmd_bus.y_end     <= c.ye;
    do @(posedge clk); while (!cmd_bus.ready);
    if (predict_pixel(c, want)) begin
      pending_pixels.push_back(want);
      pixels_predicted++;
    end
  endtask

  // Holds the sender off until every owed pixel has arrived.
  task automatic wait_for_pixels();
    cmd_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Pixel checker: compares each pixel transaction with the oldest expectation.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst) begin
      pix_bus.ready <= 1'b0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel with no expectation: pixel_x %0d pixel_y %0d last_pixel %0b",
                 pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last_pixel);
          failures++;
        end else begin
          want = pending_pixels.pop_front();
          if (pix_bus.pixel_x !== want.col) begin
            $error("pixel_x: expected %0d, actual %0d", want.col, pix_bus.pixel_x);
            failures++;
          end
          if (pix_bus.pixel_y !== want.row) begin
            $error("pixel_y: expected %0d, actual %0d", want.row, pix_bus.pixel_y);
            failures++;
          end
          if (pix_bus.last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, actual %0b", want.last, pix_bus.last_pixel);
            failures++;
          end
        end
      end
      pix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // A step with no line in progress must give nothing.
  task automatic test_step_while_idle();
    send_cmd(line_cmd_t'{OP_STEP, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
  endtask

  // Equal endpoints give the point twice, then the block is idle again.
  task automatic test_single_point_lines();
    send_cmd(line_cmd_t'{OP_START, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_STEP, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
  endtask

  // A start in the middle of a line drops it and begins the new one.
  task automatic test_restart_while_busy();
    send_cmd(line_cmd_t'{OP_START, 10'd0, 10'd1023, 10'd1023, 10'd0});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
    send_cmd(line_cmd_t'{OP_START, 10'd1023, 10'd0, 10'd0, 10'd1023});
    send_cmd(line_cmd_t'{OP_STEP, 10'd0, 10'd0, 10'd0, 10'd0});
  endtask

  // Short lines run to their end, the first with a step past the end.
  task automatic test_short_lines();
    send_cmd(line_cmd_t'{OP_START, 10'd5, 10'd5, 10'd8, 10'd3});
    repeat (5) send_cmd(rand_cmd(OP_STEP));
    send_cmd(line_cmd_t'{OP_START, 10'd10, 10'd2, 10'd10, 10'd4});
    repeat (3) send_cmd(rand_cmd(OP_STEP));
  endtask

  // The longest line the panel allows, run to the last pixel.
  task automatic test_full_span_line();
    send_cmd(line_cmd_t'{OP_START, 10'd1023, 10'd0, 10'd0, 10'd700});
    repeat (COORD_MAX + 2) send_cmd(rand_cmd(OP_STEP));
  endtask

  // Mostly well-formed lines with random content, plus stray steps and wild starts.
  task automatic test_random_lines(input int target);
    int        first_count;
    int        pick;
    int        major;
    int        n_steps;
    int        dx;
    int        dy;
    line_cmd_t c;
    first_count = pixels_predicted;
    while (pixels_predicted - first_count < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_cmd(rand_cmd(OP_STEP));
      end else if (pick < 13) begin
        send_cmd(rand_cmd(OP_START));
        repeat ($urandom_range(6)) send_cmd(rand_cmd(OP_STEP));
      end else begin
        c = rand_cmd(OP_START);
        c.xe = pick_end(c.xs);
        c.ye = pick_end(c.ys);
        dx = int'(c.xe) - int'(c.xs);
        dy = int'(c.ye) - int'(c.ys);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        major = (dx > dy) ? dx : dy;
        n_steps = major + 1;
        pick = $urandom_range(99);
        // Long lines and some short ones are cut off by the next start.
        if (major > 40 || pick < 12) begin
          n_steps = $urandom_range(0, (major > 20) ? 20 : major);
        end else if (pick < 24) begin
          n_steps += $urandom_range(1, 3);
        end
        send_cmd(c);
        repeat (n_steps) send_cmd(rand_cmd(OP_STEP));
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.operation <= OP_STEP;
    cmd_bus.x_start   <= '0;
    cmd_bus.y_start   <= '0;
    cmd_bus.x_end     <= '0;
    cmd_bus.y_end     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0, 0);
    test_step_while_idle();
    test_single_point_lines();
    test_restart_while_busy();
    test_short_lines();
    wait_for_pixels();

    set_idling(30, 30);
    test_full_span_line();
    wait_for_pixels();

    set_idling(0, 0);
    test_random_lines(170);
    wait_for_pixels();
    set_idling(75, 0);
    test_random_lines(170);
    wait_for_pixels();
    set_idling(0, 75);
    test_random_lines(170);
    wait_for_pixels();
    set_idling(30, 30);
    test_random_lines(170);
    wait_for_pixels();

    if (failures == 0) begin
      $display("line_pixel_generator_core test passed");
    end else begin
      $display("line_pixel_generator_core test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("line_pixel_generator_core test failed");
    $finish;
  end

endmodule
